// ===== rtl/ect_pkg.sv =====
// Shared types, token codes and character constants for the expression tokenizer.
package ect_pkg;

    // Token kinds as they appear on token_kind.
    localparam logic [4:0] KIND_INT     = 5'd0;
    localparam logic [4:0] KIND_MINUS   = 5'd1;
    localparam logic [4:0] KIND_TILDE   = 5'd2;
    localparam logic [4:0] KIND_STAR    = 5'd3;
    localparam logic [4:0] KIND_SLASH   = 5'd4;
    localparam logic [4:0] KIND_PERCENT = 5'd5;
    localparam logic [4:0] KIND_SHL     = 5'd6;
    localparam logic [4:0] KIND_SHR     = 5'd7;
    localparam logic [4:0] KIND_AND     = 5'd8;
    localparam logic [4:0] KIND_PLUS    = 5'd9;
    localparam logic [4:0] KIND_OR      = 5'd10;
    localparam logic [4:0] KIND_XOR     = 5'd11;
    localparam logic [4:0] KIND_POWER   = 5'd12;
    localparam logic [4:0] KIND_LPAREN  = 5'd13;
    localparam logic [4:0] KIND_RPAREN  = 5'd14;
    localparam logic [4:0] KIND_END     = 5'd15;
    localparam logic [4:0] KIND_INVALID = 5'd16;

    // Characters the lexer recognizes.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LT      = 8'h3C;
    localparam logic [7:0] CHAR_GT      = 8'h3E;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_AND     = 8'h26;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_OR      = 8'h7C;
    localparam logic [7:0] CHAR_XOR     = 8'h5E;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;

    // Token queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // First character held while waiting for a possible second one.
    typedef enum logic [3:0] {
        HOLD_NONE = 4'b0001,
        HOLD_LT   = 4'b0010,
        HOLD_GT   = 4'b0100,
        HOLD_STAR = 4'b1000
    } hold_t;

    // One token; only the first token of a character can be an integer.
    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] value;
        logic [7:0]  bad;
    } tok_t;

    // All tokens caused by one character: one or two.
    typedef struct packed {
        logic       two;
        tok_t       tok0;
        logic [4:0] kind1;
        logic [7:0] bad1;
    } entry_t;

    // Lexer state flags reported by the front.
    typedef struct packed {
        logic in_number;
        logic holding;
    } front_stat_t;

    // Outcome of lexing a character with nothing open.
    typedef struct packed {
        logic       emit;
        logic [4:0] kind;
        logic [7:0] bad;
        hold_t      hold;
        logic       start_num;
    } fresh_t;

    function automatic fresh_t lex_fresh(input logic [7:0] c);
        fresh_t f;
        f.emit      = 1'b1;
        f.kind      = KIND_INVALID;
        f.bad       = 8'd0;
        f.hold      = HOLD_NONE;
        f.start_num = 1'b0;
        case (c) inside
            [CHAR_ZERO:CHAR_NINE]:
            begin
                f.emit      = 1'b0;
                f.start_num = 1'b1;
            end
            CHAR_SPACE:   f.emit = 1'b0;
            CHAR_LT:
            begin
                f.emit = 1'b0;
                f.hold = HOLD_LT;
            end
            CHAR_GT:
            begin
                f.emit = 1'b0;
                f.hold = HOLD_GT;
            end
            CHAR_STAR:
            begin
                f.emit = 1'b0;
                f.hold = HOLD_STAR;
            end
            CHAR_MINUS:   f.kind = KIND_MINUS;
            CHAR_TILDE:   f.kind = KIND_TILDE;
            CHAR_SLASH:   f.kind = KIND_SLASH;
            CHAR_PERCENT: f.kind = KIND_PERCENT;
            CHAR_AND:     f.kind = KIND_AND;
            CHAR_PLUS:    f.kind = KIND_PLUS;
            CHAR_OR:      f.kind = KIND_OR;
            CHAR_XOR:     f.kind = KIND_XOR;
            CHAR_LPAREN:  f.kind = KIND_LPAREN;
            CHAR_RPAREN:  f.kind = KIND_RPAREN;
            CHAR_NUL:     f.kind = KIND_END;
            default:      f.bad = c;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/ect_front.sv =====
// Front end: takes characters, keeps the lexer state and forms the tokens of each character.
module ect_front
    import ect_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_in,
    input  logic        fifo_full,
    output logic        fifo_push,
    output entry_t      fifo_data,
    output front_stat_t stat
);

    logic [63:0] accum_reg;
    logic [63:0] accum_next;
    logic        in_number_reg;
    logic        in_number_next;
    hold_t       hold_reg;
    hold_t       hold_next;

    logic        accept;
    logic        is_digit;
    logic [63:0] digit;
    fresh_t      fresh;
    logic        has0;
    logic        has1;
    entry_t      entry;

    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    assign digit    = {60'd0, char_in[3:0]};
    assign fresh    = lex_fresh(char_in);

    // Decide the tokens and the next lexer state for the current character.
    always_comb
    begin
        has0           = 1'b0;
        has1           = 1'b0;
        entry          = '0;
        accum_next     = accum_reg;
        in_number_next = in_number_reg;
        hold_next      = hold_reg;

        if (in_number_reg && is_digit)
        begin
            accum_next = (accum_reg << 3) + (accum_reg << 1) + digit;
        end
        else if (in_number_reg || (hold_reg != HOLD_NONE))
        begin
            // Close the open number or held first character.
            has0 = 1'b1;
            in_number_next = 1'b0;
            hold_next = HOLD_NONE;
            if (in_number_reg)
            begin
                entry.tok0.kind  = KIND_INT;
                entry.tok0.value = accum_reg;
                has1 = fresh.emit;
            end
            else
            begin
                case (hold_reg)
                    HOLD_LT:
                    begin
                        if (char_in == CHAR_LT)
                        begin
                            entry.tok0.kind = KIND_SHL;
                        end
                        else
                        begin
                            entry.tok0.kind = KIND_INVALID;
                            entry.tok0.bad  = CHAR_LT;
                            has1 = fresh.emit;
                        end
                    end
                    HOLD_GT:
                    begin
                        if (char_in == CHAR_GT)
                        begin
                            entry.tok0.kind = KIND_SHR;
                        end
                        else
                        begin
                            entry.tok0.kind = KIND_INVALID;
                            entry.tok0.bad  = CHAR_GT;
                            has1 = fresh.emit;
                        end
                    end
                    default:
                    begin
                        if (char_in == CHAR_STAR)
                        begin
                            entry.tok0.kind = KIND_POWER;
                        end
                        else
                        begin
                            entry.tok0.kind = KIND_STAR;
                            has1 = fresh.emit;
                        end
                    end
                endcase
            end
            // The character itself is lexed fresh unless it completed a pair.
            if (in_number_reg || has1 || (entry.tok0.kind == KIND_INVALID)
                || (entry.tok0.kind == KIND_STAR))
            begin
                in_number_next = fresh.start_num;
                hold_next      = fresh.hold;
                if (fresh.start_num)
                begin
                    accum_next = digit;
                end
            end
            entry.two   = has1;
            entry.kind1 = fresh.kind;
            entry.bad1  = fresh.bad;
        end
        else
        begin
            has0 = fresh.emit;
            entry.tok0.kind = fresh.kind;
            entry.tok0.bad  = fresh.bad;
            in_number_next  = fresh.start_num;
            hold_next       = fresh.hold;
            if (fresh.start_num)
            begin
                accum_next = digit;
            end
        end
    end

    assign fifo_push = accept && has0;
    assign fifo_data = entry;

    // Lexer state advances on every accepted character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= '0;
            in_number_reg <= 1'b0;
            hold_reg      <= HOLD_NONE;
        end
        else if (accept)
        begin
            accum_reg     <= accum_next;
            in_number_reg <= in_number_next;
            hold_reg      <= hold_next;
        end
    end

    assign stat.in_number = in_number_reg;
    assign stat.holding   = (hold_reg != HOLD_NONE);

endmodule

// ===== rtl/ect_fifo.sv =====
// Short queue of per-character token groups between the front and the back.
module ect_fifo
    import ect_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_data,
    output logic   full,
    input  logic   rd_en,
    output entry_t rd_data,
    output logic   empty
);

    entry_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ect_drain.sv =====
// Back end: holds one token group and presents its tokens one per transfer.
module ect_drain
    import ect_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fifo_empty,
    input  entry_t      fifo_data,
    output logic        fifo_pop,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  token_kind,
    output logic [63:0] int_value,
    output logic [7:0]  bad_char,
    output logic        last_of_run
);

    entry_t cur_reg;
    logic   valid_reg;
    logic   phase_reg;
    logic   take;
    logic   last;
    logic   load;

    assign last     = phase_reg || !cur_reg.two;
    assign take     = valid_reg && pop;
    assign load     = !valid_reg || (take && last);
    assign fifo_pop = load && !fifo_empty;

    // Payload of the group being delivered.
    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            cur_reg <= fifo_data;
        end
    end

    // Occupancy and position within the group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !fifo_empty;
            phase_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= 1'b1;
        end
    end

    // Select the token on the result ports.
    assign empty       = !valid_reg;
    assign token_kind  = phase_reg ? cur_reg.kind1 : cur_reg.tok0.kind;
    assign int_value   = phase_reg ? 64'd0 : cur_reg.tok0.value;
    assign bad_char    = phase_reg ? cur_reg.bad1 : cur_reg.tok0.bad;
    assign last_of_run = last;

endmodule

// ===== rtl/expression_char_tokenizer.sv =====
// Top level of the expression tokenizer: front end, token queue and back end.
//
// Channel   Direction  Handshake     Payload
// input     in         push / full   char_in
// result    out        pop / empty   token_kind, int_value, bad_char, last_of_run
//
// A character is taken every cycle while the four-entry token queue has room; the
// front end decides its tokens in the same cycle with one 64-bit multiply-by-ten add.
// A character that causes two tokens holds the back end for two result transfers,
// so the sustained rate is one character per cycle when each gives at most one token.
// Reset clears the lexer state, the queue and the output stage; no pass is needed.
// A stalled result side fills the queue and then raises full.
module expression_char_tokenizer
    import ect_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_in,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  token_kind,
    output logic [63:0] int_value,
    output logic [7:0]  bad_char,
    output logic        last_of_run
);

    logic        fifo_push;
    entry_t      fifo_wdata;
    logic        fifo_full;
    logic        fifo_pop;
    entry_t      fifo_rdata;
    logic        fifo_empty;
    front_stat_t stat;

    ect_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_in   (char_in),
        .fifo_full (fifo_full),
        .fifo_push (fifo_push),
        .fifo_data (fifo_wdata),
        .stat      (stat)
    );

    ect_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fifo_push),
        .wr_data (fifo_wdata),
        .full    (fifo_full),
        .rd_en   (fifo_pop),
        .rd_data (fifo_rdata),
        .empty   (fifo_empty)
    );

    ect_drain u_drain (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .fifo_data   (fifo_rdata),
        .fifo_pop    (fifo_pop),
        .empty       (empty),
        .pop         (pop),
        .token_kind  (token_kind),
        .int_value   (int_value),
        .bad_char    (bad_char),
        .last_of_run (last_of_run)
    );

`ifndef SYNTHESIS
    // An open number and a held first character never coexist.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.in_number && stat.holding))
        else $error("number run and held character both open");

    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_push && fifo_full))
        else $error("token group pushed into a full queue");

    // A token that is not last is followed at once by the rest of its group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=> !empty)
        else $error("second token of a group went missing");
`endif

endmodule
